// ===== src/eds_pkg.sv =====
`default_nettype none
package eds_pkg;

    typedef enum logic [1:0] {
        MODE_FIRST  = 2'd0,
        MODE_SECOND = 2'd1,
        MODE_END    = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam int unsigned FRAC_BITS = 16;
    localparam logic [16:0] SIM_ONE   = 17'h10000;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage
`default_nettype wire

// ===== src/eds_cell.sv =====
`default_nettype none
module eds_cell
    import eds_pkg::*;
#(
    parameter int unsigned LW = 9
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          init,
    input  wire logic [LW-1:0] init_cost,
    input  wire logic          load,
    input  wire logic [7:0]    load_sym,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_sym,
    input  wire logic [LW-1:0] in_left,
    input  wire logic [LW-1:0] in_diag,
    output logic               out_valid,
    output logic [7:0]         out_sym,
    output logic [LW-1:0]      out_left,
    output logic [LW-1:0]      out_diag,
    output logic [LW-1:0]      cost
);

    logic [LW-1:0] cost_reg;
    logic [7:0]    sym_reg;
    logic          valid_reg;
    logic [7:0]    osym_reg;
    logic [LW-1:0] left_reg;
    logic [LW-1:0] diag_reg;
    logic [LW:0]   up_c;
    logic [LW:0]   lf_c;
    logic [LW:0]   dg_c;
    logic [LW:0]   m_c;
    logic [LW-1:0] cost_next;

    always_comb begin
        up_c = {1'b0, cost_reg} + 1'b1;
        lf_c = {1'b0, in_left} + 1'b1;
        dg_c = {1'b0, in_diag} + {{LW{1'b0}}, (in_sym != sym_reg)};
        m_c  = (up_c < lf_c) ? up_c : lf_c;
        m_c  = (m_c < dg_c) ? m_c : dg_c;
        cost_next = m_c[LW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid && !init;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sym_reg <= load_sym;
        end
        if (init) begin
            cost_reg <= init_cost;
        end else if (in_valid) begin
            cost_reg <= cost_next;
            left_reg <= cost_next;
            diag_reg <= cost_reg;
            osym_reg <= in_sym;
        end
    end

    assign out_valid = valid_reg;
    assign out_sym   = osym_reg;
    assign out_left  = left_reg;
    assign out_diag  = diag_reg;
    assign cost      = cost_reg;

endmodule
`default_nettype wire

// ===== src/eds_div.sv =====
`default_nettype none
module eds_div
    import eds_pkg::*;
#(
    parameter int unsigned LW = 9
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [LW-1:0]    num,
    input  wire logic [LW-1:0]    den,
    output logic                  done,
    output logic [LW+FRAC_BITS-1:0] quot
);

    localparam int unsigned NW = LW + FRAC_BITS;
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [LW-1:0] rem_reg;
    logic [LW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          done_reg;
    logic [LW:0]   trial;
    logic          fits;

    always_comb begin
        trial    = {rem_reg, quo_reg[NW-1]};
        fits     = trial >= {1'b0, den_reg};
        cnt_next = cnt_reg;
        if (start) begin
            cnt_next = CW'(NW);
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= !start && (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= {num, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= fits ? LW'(trial - {1'b0, den_reg}) : trial[LW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
`default_nettype wire

// ===== src/edit_distance_similarity_unit.sv =====
`default_nettype none
// channel   dir  tdata                              tuser
// s_*       in   [7:0] symbol                       [1:0] mode
// m_*       out  [8:0] distance, [25:9] similarity  [0] overflow
//
// symbol words are accepted one per cycle while idle; an end word with two non-empty
// strings is processed in steps: the first string is streamed one row per cycle
// through a row of MAX_LEN cells, the wavefront drains through the whole row,
// then a bit-serial divider runs
// aresetn is synchronous; lengths, overflow and control clear, stores do not
// input is stalled from an end word until its result is in the output register
module edit_distance_similarity_unit
    import eds_pkg::*;
#(
    parameter int unsigned MAX_LEN = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // symbol
    input  wire logic [1:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // distance, similarity, zero pad
    output logic [0:0]       m_tuser    // overflow
);

    localparam int unsigned LW = $clog2(MAX_LEN + 1);
    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned NW = LW + FRAC_BITS;

    state_t state_reg, state_next;

    logic [7:0]    mem [MAX_LEN];
    logic [7:0]    rdata_reg;
    logic [LW-1:0] len1_reg, len2_reg;
    logic          ovf_reg;
    logic [LW-1:0] run_n_reg, run_m_reg, maxlen_reg;
    logic [LW-1:0] rd_reg;
    logic          feed_v_reg;
    logic [LW-1:0] row_reg;
    logic [LW:0]   drain_reg;
    logic          res_ovf_reg;
    logic [LW-1:0] res_dist_reg;
    logic [16:0]   res_sim_reg;
    logic          mv_reg;
    logic [31:0]   mdata_reg;
    logic          mu_reg;
    logic          init;
    logic          acc;
    mode_t         mode;
    logic          div_start;
    logic          div_done;
    logic [NW-1:0] quot;
    logic [LW+8:0] dist_ext;
    logic [AW-1:0] sel;

    logic          cv [MAX_LEN+1];
    logic [7:0]    cs [MAX_LEN+1];
    logic [LW-1:0] cl [MAX_LEN+1];
    logic [LW-1:0] cd [MAX_LEN+1];
    logic [LW-1:0] cc [MAX_LEN];

    assign mode     = mode_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign init     = acc && (mode == MODE_END);

    assign cv[0] = feed_v_reg;
    assign cs[0] = rdata_reg;
    assign cl[0] = row_reg;
    assign cd[0] = row_reg - 1'b1;

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        eds_cell #(.LW(LW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .init      (init),
            .init_cost (LW'(k + 1)),
            .load      (acc && (mode == MODE_SECOND) && (len2_reg == LW'(k))),
            .load_sym  (s_tdata),
            .in_valid  (cv[k]),
            .in_sym    (cs[k]),
            .in_left   (cl[k]),
            .in_diag   (cd[k]),
            .out_valid (cv[k+1]),
            .out_sym   (cs[k+1]),
            .out_left  (cl[k+1]),
            .out_diag  (cd[k+1]),
            .cost      (cc[k])
        );
    end

    assign sel = AW'(run_m_reg - 1'b1);
    assign div_start = (state_reg == ST_DRAIN) && (drain_reg == '0);

    eds_div #(.LW(LW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (cc[sel]),
        .den     (maxlen_reg),
        .done    (div_done),
        .quot    (quot)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (init) begin
                    state_next = (len1_reg == '0 || len2_reg == '0) ? ST_OUT : ST_FEED;
                end
            end
            ST_FEED: begin
                if (rd_reg == run_n_reg - 1'b1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_reg == '0) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            len1_reg   <= '0;
            len2_reg   <= '0;
            ovf_reg    <= 1'b0;
            feed_v_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            feed_v_reg <= (state_reg == ST_FEED);
            if (acc) begin
                case (mode)
                    MODE_FIRST: begin
                        if (len1_reg < LW'(MAX_LEN)) len1_reg <= len1_reg + 1'b1;
                        else ovf_reg <= 1'b1;
                    end
                    MODE_SECOND: begin
                        if (len2_reg < LW'(MAX_LEN)) len2_reg <= len2_reg + 1'b1;
                        else ovf_reg <= 1'b1;
                    end
                    MODE_END: begin
                        len1_reg <= '0;
                        len2_reg <= '0;
                        ovf_reg  <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && (!mv_reg || m_tready)) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    assign dist_ext = {9'd0, res_dist_reg};

    always_ff @(posedge aclk) begin
        if (acc && mode == MODE_FIRST && len1_reg < LW'(MAX_LEN)) begin
            mem[len1_reg[AW-1:0]] <= s_tdata;
        end
        rdata_reg <= mem[rd_reg[AW-1:0]];
        row_reg   <= rd_reg + 1'b1;
        if (init) begin
            run_n_reg    <= len1_reg;
            run_m_reg    <= len2_reg;
            maxlen_reg   <= (len1_reg > len2_reg) ? len1_reg : len2_reg;
            res_ovf_reg  <= ovf_reg;
            res_dist_reg <= '0;
            res_sim_reg  <= '0;
            rd_reg       <= '0;
            drain_reg    <= (LW+1)'(MAX_LEN + 3);
        end
        if (state_reg == ST_FEED) begin
            rd_reg <= rd_reg + 1'b1;
        end
        if (state_reg == ST_DRAIN) begin
            drain_reg <= drain_reg - 1'b1;
            res_dist_reg <= cc[sel];
        end
        if (div_done) begin
            res_sim_reg <= SIM_ONE - quot[16:0];
        end
        if (state_reg == ST_OUT && (!mv_reg || m_tready)) begin
            mdata_reg <= {6'd0, res_sim_reg, dist_ext[8:0]};
            mu_reg    <= res_ovf_reg;
        end
    end

    assign m_tvalid   = mv_reg;
    assign m_tdata    = mdata_reg;
    assign m_tuser[0] = mu_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len1_reg <= LW'(MAX_LEN) && len2_reg <= LW'(MAX_LEN))
        else $error("string length beyond limit");

    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_done && state_reg == ST_DIV) |-> quot <= NW'(65536))
        else $error("quotient above one");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        init |=> (len1_reg == '0 && len2_reg == '0 && !ovf_reg))
        else $error("end word did not clear pair state");

endmodule
`default_nettype wire
